// ----- rtl/uvp_pkg.sv -----
// Shared types and constants for the UTF-8 path validator.
`default_nettype none
package uvp_pkg;

	typedef enum logic [2:0] {
		KIND_PLAIN = 3'd0,
		KIND_E0    = 3'd1,
		KIND_ED    = 3'd2,
		KIND_F0    = 3'd3,
		KIND_F4    = 3'd4
	} range_kind_t;

	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] ASCII_MAX   = 8'h7F;
	localparam logic [7:0] LEAD2_MIN   = 8'hC2;
	localparam logic [7:0] LEAD2_MAX   = 8'hDF;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD3_MAX   = 8'hEF;
	localparam logic [7:0] LEAD3_ED    = 8'hED;
	localparam logic [7:0] LEAD4_MIN   = 8'hF0;
	localparam logic [7:0] LEAD4_MAX   = 8'hF4;
	localparam logic [7:0] CONT_MIN    = 8'h80;
	localparam logic [7:0] CONT_MAX    = 8'hBF;
	localparam logic [7:0] CONT_E0_MIN = 8'hA0;
	localparam logic [7:0] CONT_ED_MAX = 8'h9F;
	localparam logic [7:0] CONT_F0_MIN = 8'h90;
	localparam logic [7:0] CONT_F4_MAX = 8'h8F;
	localparam logic [7:0] CONT_MASK   = 8'hC0;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		logic  advance;
		item_t item;
	} step_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/uvp_if.sv -----
// Valid/ready channel interfaces for the validator input and result.
`default_nettype none
interface uvp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, output data_byte, output has_byte, output last, input ready);
	modport sink (input valid, input data_byte, input has_byte, input last, output ready);
endinterface

interface uvp_out_if;
	logic valid;
	logic ready;
	logic status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface
`default_nettype wire

// ----- rtl/uvp_state.sv -----
// Decoder state and per-byte UTF-8 step logic.
`default_nettype none
module uvp_state
	import uvp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire step_ctl_t ctl,
	output logic           status
);

	logic [1:0]  owed_q;
	range_kind_t kind_q;
	logic        err_q;

	logic [1:0]  owed_d;
	range_kind_t kind_d;
	logic        err_d;
	logic        cont_ok;
	logic [7:0]  b;

	assign b = ctl.item.data_byte;

	always_comb begin
		case (kind_q)
			KIND_E0: cont_ok = (b >= CONT_E0_MIN) && (b <= CONT_MAX);
			KIND_ED: cont_ok = (b >= CONT_MIN) && (b <= CONT_ED_MAX);
			KIND_F0: cont_ok = (b >= CONT_F0_MIN) && (b <= CONT_MAX);
			KIND_F4: cont_ok = (b >= CONT_MIN) && (b <= CONT_F4_MAX);
			default: cont_ok = (b & CONT_MASK) == CONT_MIN;
		endcase
	end

	always_comb begin
		owed_d = owed_q;
		kind_d = kind_q;
		err_d  = err_q;
		if (ctl.item.has_byte) begin
			kind_d = KIND_PLAIN;
			if (b == BYTE_ZERO) begin
				err_d  = 1'b1;
				owed_d = 2'd0;
			end else if (owed_q != 2'd0) begin
				if (cont_ok) begin
					owed_d = owed_q - 2'd1;
				end else begin
					err_d  = 1'b1;
					owed_d = 2'd0;
				end
			end else if (b <= ASCII_MAX) begin
				owed_d = 2'd0;
			end else if ((b >= LEAD2_MIN) && (b <= LEAD2_MAX)) begin
				owed_d = 2'd1;
			end else if ((b >= LEAD3_MIN) && (b <= LEAD3_MAX)) begin
				owed_d = 2'd2;
				if (b == LEAD3_MIN) begin
					kind_d = KIND_E0;
				end else if (b == LEAD3_ED) begin
					kind_d = KIND_ED;
				end
			end else if ((b >= LEAD4_MIN) && (b <= LEAD4_MAX)) begin
				owed_d = 2'd3;
				if (b == LEAD4_MIN) begin
					kind_d = KIND_F0;
				end else if (b == LEAD4_MAX) begin
					kind_d = KIND_F4;
				end
			end else begin
				err_d = 1'b1;
			end
		end
	end

	assign status = err_d || (owed_d != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= 2'd0;
			kind_q <= KIND_PLAIN;
			err_q  <= 1'b0;
		end else if (ctl.advance) begin
			if (ctl.item.last) begin
				owed_q <= 2'd0;
				kind_q <= KIND_PLAIN;
				err_q  <= 1'b0;
			end else begin
				owed_q <= owed_d;
				kind_q <= kind_d;
				err_q  <= err_d;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/utf8_path_validator_unit.sv -----
// UTF-8 path validator: input register, decoder state step, status register.
// Checks a path string one byte per transaction as RFC 3629 UTF-8 (no overlong
// forms, no surrogates, nothing above U+10FFFF) with no zero byte. Each
// transaction is registered, then run through the decoder step; a transaction
// with last set produces one status transaction (0 valid, 1 invalid, including
// a string cut off mid-sequence), registered in the status register.
// has_byte = 0 with last = 1 ends the string without a byte (an empty string
// reports valid); has_byte = 0 with last = 0 is ignored. Sustained rate is
// one transaction per cycle; the input stalls only while a status waits in
// the output register and the sink holds ready low. The decoder returns to
// its reset state after every string.
`default_nettype none
module utf8_path_validator_unit
	import uvp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	uvp_in_if.sink     in_ch,
	uvp_out_if.source  out_ch
);

	logic      valid_s1;
	item_t     item_s1;
	logic      out_valid_q;
	logic      status_q;
	logic      slot_free;
	logic      s1_fire;
	logic      step_status;
	step_ctl_t ctl;

	assign slot_free    = !out_valid_q || out_ch.ready;
	assign s1_fire      = valid_s1 && (!item_s1.last || slot_free);
	assign in_ch.ready  = !valid_s1 || s1_fire;
	assign ctl.advance  = s1_fire;
	assign ctl.item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.has_byte  <= in_ch.has_byte;
			item_s1.last      <= in_ch.last;
		end
	end

	uvp_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.status (step_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= s1_fire && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.last) begin
			status_q <= step_status;
		end
	end

	assign out_ch.valid  = out_valid_q;
	assign out_ch.status = status_q;

endmodule
`default_nettype wire

// ----- verif/utf8_status_checker.sv -----
// Checker for the UTF-8 path validator: predicts the status of each string and compares it.
`timescale 1ns / 100ps
module utf8_status_checker
	import uvp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        status,
	output int unsigned mismatches,
	output int unsigned pending,
	output int unsigned results
);

	logic [1:0]  owed = 2'd0;
	range_kind_t cont_kind = KIND_PLAIN;
	logic        err_sticky = 1'b0;
	logic        want_status;
	logic        expected_status[$];
	int unsigned mismatch_count = 0;
	int unsigned pending_count = 0;
	int unsigned result_count = 0;

	assign mismatches = mismatch_count;
	assign pending = pending_count;
	assign results = result_count;

	function automatic logic cont_in_range(input logic [7:0] b, input range_kind_t k);
		case (k)
			KIND_E0: return b >= CONT_E0_MIN && b <= CONT_MAX;
			KIND_ED: return b >= CONT_MIN && b <= CONT_ED_MAX;
			KIND_F0: return b >= CONT_F0_MIN && b <= CONT_MAX;
			KIND_F4: return b >= CONT_MIN && b <= CONT_F4_MAX;
			default: return (b & CONT_MASK) == CONT_MIN;
		endcase
	endfunction

	task automatic clear_decoder();
		owed = 2'd0;
		cont_kind = KIND_PLAIN;
		err_sticky = 1'b0;
	endtask

	task automatic absorb_byte(input logic [7:0] b);
		if (b == BYTE_ZERO) begin
			err_sticky = 1'b1;
			owed = 2'd0;
			cont_kind = KIND_PLAIN;
		end else if (owed != 2'd0) begin
			if (cont_in_range(b, cont_kind)) begin
				owed = owed - 2'd1;
			end else begin
				err_sticky = 1'b1;
				owed = 2'd0;
			end
			cont_kind = KIND_PLAIN;
		end else begin
			cont_kind = KIND_PLAIN;
			if (b > ASCII_MAX) begin
				if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
					owed = 2'd1;
				end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
					owed = 2'd2;
					if (b == LEAD3_MIN)
						cont_kind = KIND_E0;
					else if (b == LEAD3_ED)
						cont_kind = KIND_ED;
				end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
					owed = 2'd3;
					if (b == LEAD4_MIN)
						cont_kind = KIND_F0;
					else if (b == LEAD4_MAX)
						cont_kind = KIND_F4;
				end else begin
					err_sticky = 1'b1;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_decoder();
			expected_status.delete();
			pending_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (has_byte)
					absorb_byte(data_byte);
				if (last) begin
					expected_status.push_back(err_sticky || owed != 2'd0);
					clear_decoder();
				end
			end
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					$error("status transaction with none expected: status got %0d", status);
					mismatch_count++;
				end else begin
					want_status = expected_status.pop_front();
					result_count++;
					if (status !== want_status) begin
						$error("status mismatch: expected %0d, got %0d", want_status, status);
						mismatch_count++;
					end
				end
			end
			pending_count = expected_status.size();
		end
	end

endmodule

// ----- verif/utf8_path_validator_unit_test.sv -----
// Top-level testbench for utf8_path_validator_unit: clock, reset, path strings and verdict.
`timescale 1ns / 100ps
module utf8_path_validator_unit_test;

	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 840;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	uvp_in_if  in_ch();
	uvp_out_if out_ch();

	int unsigned mismatches;
	int unsigned pending;
	int unsigned results;
	int unsigned sent_items = 0;
	int unsigned strings_sent = 0;
	int unsigned quiet_cycles = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	logic [7:0]  str_bytes[$];
	logic [20:0] boundary_cps[16] = '{
		21'h01, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFF, 21'h1000, 21'hD7FF,
		21'hE000, 21'hFFFF, 21'h10000, 21'h3FFFF, 21'h40000, 21'hFFFFF, 21'h100000,
		21'h10FFFF
	};

	utf8_path_validator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	utf8_status_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.data_byte  (in_ch.data_byte),
		.has_byte   (in_ch.has_byte),
		.last       (in_ch.last),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.status     (out_ch.status),
		.mismatches (mismatches),
		.pending    (pending),
		.results    (results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.has_byte = 1'b0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("utf8_path_validator_unit test failed");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [7:0] b, input logic h, input logic l);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.has_byte <= h;
		in_ch.last <= l;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		if (h || l)
			sent_items++;
	endtask

	// occasional ignored transaction (no byte, not last) between bytes
	task automatic send_string(input bit marker);
		int i;
		for (i = 0; i < str_bytes.size(); i++) begin
			if ($urandom_range(15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(str_bytes[i], 1'b1, !marker && i == str_bytes.size() - 1);
		end
		if (marker || str_bytes.size() == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
		strings_sent++;
	endtask

	function automatic logic [20:0] pick_code_point();
		logic [20:0] cp;
		case ($urandom_range(3))
			0: cp = 21'($urandom_range(1, 'h7F));
			1: cp = 21'($urandom_range('h80, 'h7FF));
			2: begin
				cp = 21'($urandom_range('h800, 'hFFFF));
				if (cp >= 21'hD800 && cp <= 21'hDFFF)
					cp = cp ^ 21'h4000;
			end
			default: cp = 21'($urandom_range('h10000, 'h10FFFF));
		endcase
		if ($urandom_range(7) == 0)
			cp = boundary_cps[$urandom_range(15)];
		return cp;
	endfunction

	function automatic void add_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			str_bytes.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			str_bytes.push_back({3'b110, cp[10:6]});
			str_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			str_bytes.push_back({4'b1110, cp[15:12]});
			str_bytes.push_back({2'b10, cp[11:6]});
			str_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			str_bytes.push_back({5'b11110, cp[20:18]});
			str_bytes.push_back({2'b10, cp[17:12]});
			str_bytes.push_back({2'b10, cp[11:6]});
			str_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	// mostly well-formed strings; some corrupted, some raw noise, some empty
	task automatic send_random_string();
		int mode;
		int pos;
		str_bytes.delete();
		mode = $urandom_range(99);
		if (mode < 8) begin
			repeat ($urandom_range(1, 6))
				str_bytes.push_back(8'($urandom));
		end else if (mode >= 13) begin
			repeat ($urandom_range(1, 6))
				add_code_point(pick_code_point());
			if (mode >= 75) begin
				pos = $urandom_range(str_bytes.size() - 1);
				case ($urandom_range(3))
					0: str_bytes[pos] = 8'($urandom);
					1: str_bytes.insert(pos, 8'h00);
					2: str_bytes.insert(pos, 8'($urandom_range('h80, 'hFF)));
					default: str_bytes.pop_back();
				endcase
			end
		end
		send_string($urandom_range(3) == 0);
	endtask

	initial begin
		int p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string
		str_bytes = {};
		send_string(1'b1);
		// ASCII max, then highest code point
		str_bytes = '{8'h7F, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_string(1'b0);
		// lone zero byte
		str_bytes = '{8'h00};
		send_string(1'b0);
		// overlong three-byte form
		str_bytes = '{8'hE0, 8'h9F};
		send_string(1'b0);
		// lowest three-byte form
		str_bytes = '{8'hE0, 8'hA0, 8'h80};
		send_string(1'b0);
		// surrogate, closed by end marker
		str_bytes = '{8'hED, 8'hA0};
		send_string(1'b1);
		// zero byte where a continuation is owed
		str_bytes = '{8'hC2, 8'h00};
		send_string(1'b0);
		// truncated four-byte sequence with an ignored transaction inside
		send_item(8'hF0, 1'b1, 1'b0);
		send_item(8'h90, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		strings_sent++;
		// sticky error: bad lead then valid ASCII
		str_bytes = '{8'hFF, 8'h41};
		send_string(1'b0);

		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 46; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 46; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			while (sent_items < 25 + (p + 1) * RANDOM_ITEMS / 4)
				send_random_string();
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d byte and end transactions in %0d strings under four pacing phases",
			sent_items, strings_sent);
		$display("compared %0d status results, %0d mismatches", results, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("utf8_path_validator_unit test passed");
		else
			$display("utf8_path_validator_unit test failed");
		$finish;
	end

endmodule
